[sv/mm_pkg.sv]
// package for the matrix multiply block: widths, codes, command and size types
// no dependencies; imported by every module of the block except mm_ram
package mm_pkg;

  localparam int DATA_W        = 32;
  localparam int IDX_W         = 3;
  localparam int DIM_W         = 4;
  localparam int ACC_W         = 2 * DATA_W + IDX_W;
  localparam int PADDR_W       = 4;
  localparam int PDATA_W       = 32;
  localparam int MAX_DIM_DEF   = 8;
  localparam int FRAC_BITS_DEF = 16;
  localparam int Q_DEPTH       = 2;
  localparam int Q_PTR_W       = 1;

  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_START  = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_A_ROWS = 2'd0,
    REG_A_COLS = 2'd1,
    REG_B_ROWS = 2'd2,
    REG_B_COLS = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    CMD_LOAD_A   = 2'd0,
    CMD_LOAD_B   = 2'd1,
    CMD_START    = 2'd2,
    CMD_MISMATCH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ISSUE = 2'd1,
    ST_DRAIN = 2'd2
  } bk_state_e;

  typedef struct packed {
    cmd_e              kind;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
  } cmd_t;

  // effective sizes, already clamped to 1..cap
  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } dims_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                               input logic [DIM_W-1:0] cap);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > cap) r = cap;
    return r;
  endfunction

endpackage

[sv/mm_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module mm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/mm_queue.sv]
// short command queue between the front and the back of the matrix multiply
// depends on mm_pkg
module mm_queue
  import mm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t               mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [Q_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [Q_PTR_W:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == (Q_PTR_W + 1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + Q_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + Q_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + (Q_PTR_W + 1)'(do_push) - (Q_PTR_W + 1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[sv/mm_front.sv]
// front end: takes requests, drops out-of-range loads and unused ops,
// turns the rest into queue commands; depends on mm_pkg
module mm_front
  import mm_pkg::*;
(
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  dims_t                    dims_i,
  input  logic                     q_full_i,
  output logic                     q_push_o,
  output cmd_t                     q_cmd_o
);

  logic keep;
  logic [DIM_W-1:0] row_x, col_x;

  assign row_x = {1'b0, row_i};
  assign col_x = {1'b0, col_i};

  always_comb begin
    keep            = 1'b0;
    q_cmd_o.kind    = CMD_LOAD_A;
    q_cmd_o.row     = row_i;
    q_cmd_o.col     = col_i;
    q_cmd_o.value   = value_i;
    unique case (op_i)
      OP_LOAD_A: begin
        keep         = (row_x < dims_i.a_rows) && (col_x < dims_i.a_cols);
        q_cmd_o.kind = CMD_LOAD_A;
      end
      OP_LOAD_B: begin
        keep         = (row_x < dims_i.b_rows) && (col_x < dims_i.b_cols);
        q_cmd_o.kind = CMD_LOAD_B;
      end
      OP_START: begin
        keep         = 1'b1;
        q_cmd_o.kind = (dims_i.a_cols != dims_i.b_rows) ? CMD_MISMATCH : CMD_START;
      end
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i && keep;

endmodule

[sv/mm_back.sv]
// back end: element stores, multiply-accumulate sequencer and result register
// depends on mm_pkg and mm_ram
module mm_back
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dims_t                    dims_i,
  input  logic                     cmd_valid_i,
  input  cmd_t                     cmd_i,
  output logic                     cmd_pop_o,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [DATA_W-1:0] product_o,
  output logic                     last_o,
  output logic                     error_o
);

  localparam int Cells  = MAX_DIM * MAX_DIM;
  localparam int AddrW  = (Cells > 1) ? $clog2(Cells) : 1;

  bk_state_e state_q, state_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;

  logic a_we, b_we, rd_en, acc_clr;
  logic [AddrW-1:0] wr_addr, a_raddr, b_raddr;
  logic [DATA_W-1:0] a_rdata, b_rdata;

  logic s1_vld_q, s2_vld_q;
  logic signed [2*DATA_W-1:0] prod_q;
  logic signed [ACC_W-1:0]    acc_q;
  logic signed [ACC_W-1:0]    shifted;
  logic [ACC_W-DATA_W:0]      hi_bits;
  logic [DATA_W-1:0]          sat;

  logic slot_free, i_last, j_last;
  logic out_load, out_err, out_last;

  logic                     out_valid_q;
  logic [IDX_W-1:0]         out_row_q, out_col_q;
  logic signed [DATA_W-1:0] product_q;
  logic                     last_q, error_q;

  assign wr_addr = AddrW'(32'(cmd_i.row) * MAX_DIM + 32'(cmd_i.col));
  assign a_raddr = AddrW'(32'(i_q) * MAX_DIM + 32'(k_q));
  assign b_raddr = AddrW'(32'(k_q) * MAX_DIM + 32'(j_q));

  mm_ram #(.WIDTH(DATA_W), .DEPTH(Cells)) u_a_store (
    .clk_i   (clk_i),
    .we_i    (a_we),
    .waddr_i (wr_addr),
    .wdata_i (cmd_i.value),
    .re_i    (rd_en),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mm_ram #(.WIDTH(DATA_W), .DEPTH(Cells)) u_b_store (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (wr_addr),
    .wdata_i (cmd_i.value),
    .re_i    (rd_en),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // shift back to the output format and saturate
  always_comb begin
    shifted = acc_q >>> FRAC_BITS;
    hi_bits = shifted[ACC_W-1:DATA_W-1];
    if ((&hi_bits) || !(|hi_bits)) sat = shifted[DATA_W-1:0];
    else sat = acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX;
  end

  assign slot_free = !out_valid_q || out_ready_i;
  assign i_last    = ({1'b0, i_q} == dims_i.a_rows - DIM_W'(1));
  assign j_last    = ({1'b0, j_q} == dims_i.b_cols - DIM_W'(1));

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    cmd_pop_o = 1'b0;
    a_we      = 1'b0;
    b_we      = 1'b0;
    rd_en     = 1'b0;
    acc_clr   = 1'b0;
    out_load  = 1'b0;
    out_err   = 1'b0;
    out_last  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          unique case (cmd_i.kind)
            CMD_LOAD_A: begin
              a_we      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            CMD_LOAD_B: begin
              b_we      = 1'b1;
              cmd_pop_o = 1'b1;
            end
            CMD_START: begin
              cmd_pop_o = 1'b1;
              i_d       = '0;
              j_d       = '0;
              k_d       = '0;
              state_d   = ST_ISSUE;
            end
            CMD_MISMATCH: begin
              if (slot_free) begin
                out_load  = 1'b1;
                out_err   = 1'b1;
                out_last  = 1'b1;
                cmd_pop_o = 1'b1;
              end
            end
            default: cmd_pop_o = 1'b0;
          endcase
        end
      end
      ST_ISSUE: begin
        rd_en   = 1'b1;
        acc_clr = (k_q == '0);
        k_d     = k_q + IDX_W'(1);
        if ({1'b0, k_q} == dims_i.a_cols - DIM_W'(1)) begin
          k_d     = '0;
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // sum is final once the read and multiply stages are empty
        if (!s1_vld_q && !s2_vld_q && slot_free) begin
          out_load = 1'b1;
          out_last = i_last && j_last;
          state_d  = ST_ISSUE;
          if (j_last) begin
            j_d = '0;
            if (i_last) state_d = ST_IDLE;
            else i_d = i_q + IDX_W'(1);
          end else begin
            j_d = j_q + IDX_W'(1);
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      i_q      <= i_d;
      j_q      <= j_d;
      k_q      <= k_d;
      s1_vld_q <= rd_en;
      s2_vld_q <= s1_vld_q;
      if (out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) prod_q <= $signed(a_rdata) * $signed(b_rdata);
    if (acc_clr) acc_q <= '0;
    else if (s2_vld_q) acc_q <= acc_q + ACC_W'(prod_q);
    if (out_load) begin
      out_row_q <= out_err ? '0 : i_q;
      out_col_q <= out_err ? '0 : j_q;
      product_q <= out_err ? '0 : sat;
      last_q    <= out_last;
      error_q   <= out_err;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign product_o   = product_q;
  assign last_o      = last_q;
  assign error_o     = error_q;

endmodule

[sv/matrix_multiply.sv]
// top level of the dense matrix multiply: size registers, front end, queue, back end
// depends on mm_pkg, mm_front, mm_queue, mm_back (and mm_ram below it)
module matrix_multiply
  import mm_pkg::*;
#(
  parameter int MAX_DIM   = MAX_DIM_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // size registers
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [PADDR_W-1:0]       paddr,
  input  logic [PDATA_W-1:0]       pwdata,
  output logic [PDATA_W-1:0]       prdata,
  output logic                     pready,
  // requests
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               op_i,
  input  logic [IDX_W-1:0]         row_i,
  input  logic [IDX_W-1:0]         col_i,
  input  logic signed [DATA_W-1:0] value_i,
  // results
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [IDX_W-1:0]         out_row_o,
  output logic [IDX_W-1:0]         out_col_o,
  output logic signed [DATA_W-1:0] product_o,
  output logic                     last_o,
  output logic                     error_o
);

  // C = A x B over signed Q16.16 elements (FRAC_BITS fraction bits).
  // size registers at byte addresses 0, 4, 8, 12: a_rows, a_cols, b_rows, b_cols;
  // a value of 0 counts as 1 and anything above min(MAX_DIM, 8) counts as that cap,
  // but the register reads back the 4 bits written.
  // op 0 / op 1 load one element of A / B at (row, col); loads outside the sizes
  // and op 3 are dropped and give no result. op 2 starts the product: results come
  // out in row-major order with last set on the final one. when a_cols differs from
  // b_rows, a start gives a single result with error and last set and zeros elsewhere.
  // each element is an exact sum of 64-bit products in a 67-bit accumulator,
  // shifted right arithmetically by FRAC_BITS (rounds toward minus infinity)
  // and saturated to 32 bits. elements never loaded read as undefined.
  // timing: requests pass through a two-entry command queue, so a request is
  // taken every cycle until the queue fills. a load is written to its store as
  // the back end pops it, and the size-mismatch answer is popped as it enters the
  // result register. a start occupies the back end until its last element is
  // loaded: per element it does one store read per cycle per inner step, then waits
  // for the read, multiply and accumulate stages to drain and the result register
  // to be free. the single multiplier and the one read port on each store set this
  // pace. the result register frees the back end while a result waits to be taken.

  localparam int DimCap = (MAX_DIM < (1 << IDX_W)) ? MAX_DIM : (1 << IDX_W);

  logic [DIM_W-1:0] a_rows_q, a_cols_q, b_rows_q, b_cols_q;
  logic             cfg_wr;
  reg_idx_e         reg_sel;
  dims_t            dims;

  logic q_push, q_full, q_empty, q_pop;
  cmd_t q_in_cmd, q_out_cmd;

  // size registers, write on the access phase
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_sel = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_rows_q <= DIM_W'(1);
      a_cols_q <= DIM_W'(1);
      b_rows_q <= DIM_W'(1);
      b_cols_q <= DIM_W'(1);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_A_ROWS: a_rows_q <= pwdata[DIM_W-1:0];
        REG_A_COLS: a_cols_q <= pwdata[DIM_W-1:0];
        REG_B_ROWS: b_rows_q <= pwdata[DIM_W-1:0];
        REG_B_COLS: b_cols_q <= pwdata[DIM_W-1:0];
        default: a_rows_q <= a_rows_q;
      endcase
    end
  end

  // readback of the raw register bits
  always_comb begin
    unique case (reg_sel)
      REG_A_ROWS: prdata = PDATA_W'(a_rows_q);
      REG_A_COLS: prdata = PDATA_W'(a_cols_q);
      REG_B_ROWS: prdata = PDATA_W'(b_rows_q);
      REG_B_COLS: prdata = PDATA_W'(b_cols_q);
      default:    prdata = '0;
    endcase
  end

  // clamped sizes shared by front and back
  assign dims.a_rows = eff_dim(a_rows_q, DIM_W'(DimCap));
  assign dims.a_cols = eff_dim(a_cols_q, DIM_W'(DimCap));
  assign dims.b_rows = eff_dim(b_rows_q, DIM_W'(DimCap));
  assign dims.b_cols = eff_dim(b_cols_q, DIM_W'(DimCap));

  mm_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .row_i      (row_i),
    .col_i      (col_i),
    .value_i    (value_i),
    .dims_i     (dims),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (q_in_cmd)
  );

  mm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (q_in_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (q_out_cmd)
  );

  mm_back #(
    .MAX_DIM   (MAX_DIM),
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dims_i      (dims),
    .cmd_valid_i (!q_empty),
    .cmd_i       (q_out_cmd),
    .cmd_pop_o   (q_pop),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .product_o   (product_o),
    .last_o      (last_o),
    .error_o     (error_o)
  );

  // a mismatch answer is a single, zeroed, final result
  a_error_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (product_o == '0) &&
                               (out_row_o == '0) && (out_col_o == '0))
    else $error("error result not marked last or not zeroed");

  // every product element lies inside the result size
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !error_o |-> ({1'b0, out_row_o} < dims.a_rows) &&
                                ({1'b0, out_col_o} < dims.b_cols))
    else $error("result index outside the product size");

  // queue can never be full and empty at once, and pops only when filled
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_full && q_empty) && !(q_pop && q_empty))
    else $error("command queue occupancy inconsistent");

endmodule

[tb/tb_matrix_multiply.sv]
// self-checking testbench for matrix_multiply: directed table, then random load/start phases
// depends on mm_pkg and the matrix_multiply rtl; product elements checked against a local model
module tb_matrix_multiply;
  import mm_pkg::*;

  // run shape
  localparam int ITEM_TARGET  = 270;
  localparam int CALM_ITEMS   = 50;
  localparam int DRAIN_CYCLES = 32;
  localparam int CYCLE_LIMIT  = 2000000;
  localparam int DIM_CAP      = (MAX_DIM_DEF < 8) ? MAX_DIM_DEF : 8;

  // op code with no function in the block
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // saturation bounds of the q16.16 result, at accumulator width
  localparam logic signed [127:0] Q_MAX = 128'sd2147483647;
  localparam logic signed [127:0] Q_MIN = -128'sd2147483648;

  typedef struct packed {
    logic [IDX_W-1:0]  out_row;
    logic [IDX_W-1:0]  out_col;
    logic [DATA_W-1:0] product;
    logic              last;
    logic              error;
  } elem_t;

  // one row of the directed plan: a size write or a request
  typedef struct packed {
    logic              is_size;
    reg_idx_e          ridx;
    logic [DIM_W-1:0]  rval;
    logic [1:0]        op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [DATA_W-1:0] value;
    logic              typed;
    elem_t             want;
  } plan_row_t;

  // dut signals; the driven ones are known from time zero
  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [PDATA_W-1:0] pwdata   = '0;
  logic [PDATA_W-1:0] prdata;
  logic              pready;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [1:0]        in_op     = '0;
  logic [IDX_W-1:0]  in_row    = '0;
  logic [IDX_W-1:0]  in_col    = '0;
  logic [DATA_W-1:0] in_value  = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_row;
  logic [IDX_W-1:0]  out_col;
  logic [DATA_W-1:0] product;
  logic              last;
  logic              error;

  // shadow of the size registers and the two element stores
  logic [DIM_W-1:0]  size_reg [4];
  logic [DATA_W-1:0] a_mem [MAX_DIM_DEF*MAX_DIM_DEF];
  logic [DATA_W-1:0] b_mem [MAX_DIM_DEF*MAX_DIM_DEF];
  bit                a_set [MAX_DIM_DEF*MAX_DIM_DEF];
  bit                b_set [MAX_DIM_DEF*MAX_DIM_DEF];

  elem_t     pending_elems[$];   // product elements still owed by the dut
  elem_t     fresh_elems[$];     // elements caused by the latest request
  plan_row_t plan[$];

  int errors      = 0;
  int cycles      = 0;
  int taken_count = 0;           // requests accepted by the dut
  int gap_pct     = 0;           // sender idle chance per request
  int stall_pct   = 0;           // receiver stall chance per cycle
  int stall_left  = 0;
  bit calm        = 1'b0;        // no idling near the end

  matrix_multiply dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .op_i        (in_op),
    .row_i       (in_row),
    .col_i       (in_col),
    .value_i     (in_value),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .product_o   (product),
    .last_o      (last),
    .error_o     (error)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // size register value as the block uses it: zero reads as one, big values clamp
  function automatic int unsigned eff_size(input logic [DIM_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > DIM_CAP) return DIM_CAP;
    return 32'(raw);
  endfunction

  // model of one accepted request: updates the stores and fills fresh_elems
  // returns 1 when the request did something (stored a value or started)
  function automatic bit compute_product_elems(input logic [1:0] op,
                                               input logic [IDX_W-1:0] row,
                                               input logic [IDX_W-1:0] col,
                                               input logic [DATA_W-1:0] value);
    int unsigned ar, ac, br, bc, i, j, k;
    logic signed [127:0] acc, sh;
    longint term;
    elem_t e;
    ar = eff_size(size_reg[REG_A_ROWS]);
    ac = eff_size(size_reg[REG_A_COLS]);
    br = eff_size(size_reg[REG_B_ROWS]);
    bc = eff_size(size_reg[REG_B_COLS]);
    fresh_elems.delete();
    case (op)
      OP_LOAD_A: begin
        if (row >= ar || col >= ac) return 0;
        a_mem[row*MAX_DIM_DEF+col] = value;
        a_set[row*MAX_DIM_DEF+col] = 1'b1;
        return 1;
      end
      OP_LOAD_B: begin
        if (row >= br || col >= bc) return 0;
        b_mem[row*MAX_DIM_DEF+col] = value;
        b_set[row*MAX_DIM_DEF+col] = 1'b1;
        return 1;
      end
      OP_START: begin
        // inner sizes disagree: one flagged element only
        if (ac != br) begin
          e = '{out_row: '0, out_col: '0, product: '0, last: 1'b1, error: 1'b1};
          fresh_elems.insert(fresh_elems.size(), e);
          return 1;
        end
        for (i = 0; i < ar; i++) begin
          for (j = 0; j < bc; j++) begin
            acc = '0;
            for (k = 0; k < ac; k++) begin
              term = longint'(int'(a_mem[i*MAX_DIM_DEF+k])) *
                     longint'(int'(b_mem[k*MAX_DIM_DEF+j]));
              acc = acc + term;
            end
            // arithmetic shift rounds toward minus infinity
            sh = acc >>> FRAC_BITS_DEF;
            e.out_row = IDX_W'(i);
            e.out_col = IDX_W'(j);
            if (sh > Q_MAX) e.product = SAT_MAX;
            else if (sh < Q_MIN) e.product = SAT_MIN;
            else e.product = sh[DATA_W-1:0];
            e.last  = (i == ar - 1) && (j == bc - 1);
            e.error = 1'b0;
            fresh_elems.insert(fresh_elems.size(), e);
          end
        end
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // receiver side: random stall bursts
  always @(posedge clk) begin
    if (stall_left == 0 && !calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
      stall_left = $urandom_range(1, 8);
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker: each accepted element against the oldest one owed
  always @(posedge clk) begin
    elem_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_elems.size() == 0) begin
        $error("unexpected result: row %0d col %0d product %h last %b error %b",
               out_row, out_col, product, last, error);
        errors++;
      end else begin
        want = pending_elems.pop_front();
        if (out_row !== want.out_row) begin
          $error("out_row: expected %0d, actual %0d", want.out_row, out_row);
          errors++;
        end
        if (out_col !== want.out_col) begin
          $error("out_col: expected %0d, actual %0d", want.out_col, out_col);
          errors++;
        end
        if (product !== want.product) begin
          $error("product: expected %h, actual %h", want.product, product);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, last);
          errors++;
        end
        if (error !== want.error) begin
          $error("error: expected %b, actual %b", want.error, error);
          errors++;
        end
      end
    end
  end

  // drive one request, wait for its handshake, then predict it
  // called at a rising edge; leaves valid high so the caller can chain requests
  task automatic send_request(input logic [1:0] op, input logic [IDX_W-1:0] row,
                              input logic [IDX_W-1:0] col, input logic [DATA_W-1:0] value,
                              input bit typed, input elem_t want);
    if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_row   <= row;
    in_col   <= col;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    void'(compute_product_elems(op, row, col, value));
    taken_count++;
    if (typed) pending_elems.insert(pending_elems.size(), want);
    else pending_elems = {pending_elems, fresh_elems};
  endtask

  // stop requests and hold off until every owed element has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_elems.size() != 0) @(posedge clk);
    // loads give no result and may still be in flight
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write one size register, then read it back
  task automatic set_size(input reg_idx_e idx, input logic [DIM_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= {(PDATA_W-DIM_W)'($urandom()), val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    size_reg[idx] = val;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    // read back
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[DIM_W-1:0] !== val) begin
      $error("size register %0d: expected %h, actual %h", idx, val, prdata[DIM_W-1:0]);
      errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // element value: mostly modest q16.16 numbers, some raw words and corner values
  function automatic logic [DATA_W-1:0] pick_value();
    logic [DATA_W-1:0] v;
    int sel;
    v   = $urandom();
    sel = $urandom_range(0, 99);
    if (sel < 50) return {{(DATA_W-21){v[20]}}, v[20:0]};
    if (sel < 75) return v;
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      4:       return 32'h0001_0000;
      default: return 32'hFFFF_0000;
    endcase
  endfunction

  // raw size value, small most of the time, sometimes zero or above the cap
  function automatic logic [DIM_W-1:0] pick_size();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return DIM_W'($urandom_range(1, 3));
    if (sel < 75) return DIM_W'($urandom_range(4, 8));
    if (sel < 85) return '0;
    if (sel < 95) return DIM_W'($urandom_range(9, 15));
    return DIM_W'(8);
  endfunction

  // load every element a start under the current sizes would read but never got
  task automatic fill_unwritten();
    int unsigned ar, ac, br, bc, r, c;
    ar = eff_size(size_reg[REG_A_ROWS]);
    ac = eff_size(size_reg[REG_A_COLS]);
    br = eff_size(size_reg[REG_B_ROWS]);
    bc = eff_size(size_reg[REG_B_COLS]);
    if (ac != br) return;
    for (r = 0; r < ar; r++)
      for (c = 0; c < ac; c++)
        if (!a_set[r*MAX_DIM_DEF+c])
          send_request(OP_LOAD_A, IDX_W'(r), IDX_W'(c), pick_value(), 1'b0, '0);
    for (r = 0; r < br; r++)
      for (c = 0; c < bc; c++)
        if (!b_set[r*MAX_DIM_DEF+c])
          send_request(OP_LOAD_B, IDX_W'(r), IDX_W'(c), pick_value(), 1'b0, '0);
  endtask

  // directed plan builders
  function automatic plan_row_t plan_req(input logic [1:0] op, input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [DATA_W-1:0] value);
    plan_row_t p;
    p       = '0;
    p.op    = op;
    p.row   = row;
    p.col   = col;
    p.value = value;
    return p;
  endfunction

  // a start whose single element is known by inspection
  function automatic plan_row_t plan_start(input logic [DATA_W-1:0] prod, input logic err);
    plan_row_t p;
    p       = plan_req(OP_START, 3'd7, 3'd7, 32'hFFFF_FFFF);
    p.typed = 1'b1;
    p.want  = '{out_row: '0, out_col: '0, product: prod, last: 1'b1, error: err};
    return p;
  endfunction

  function automatic plan_row_t plan_size(input reg_idx_e idx, input logic [DIM_W-1:0] val);
    plan_row_t p;
    p         = '0;
    p.is_size = 1'b1;
    p.ridx    = idx;
    p.rval    = val;
    return p;
  endfunction

  // append one row to the directed plan
  function automatic void add_plan(input plan_row_t p);
    plan.insert(plan.size(), p);
  endfunction

  initial begin
    int unsigned phase, n_req, sel, ar, ac, br, bc;
    logic [DIM_W-1:0] sz [4];

    foreach (size_reg[r]) size_reg[r] = DIM_W'(1);
    foreach (a_set[m]) begin
      a_set[m] = 1'b0;
      b_set[m] = 1'b0;
    end

    // directed plan, all at the 1x1 reset sizes except the size rows
    add_plan(plan_req(OP_LOAD_A, 3'd0, 3'd0, 32'h0001_0000));
    add_plan(plan_req(OP_LOAD_B, 3'd0, 3'd0, 32'h0002_0000));
    add_plan(plan_start(32'h0002_0000, 1'b0));          // 1.0 * 2.0
    add_plan(plan_req(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF));
    add_plan(plan_req(OP_LOAD_B, 3'd0, 3'd0, 32'h7FFF_FFFF));
    add_plan(plan_start(SAT_MAX, 1'b0));                // positive saturation
    add_plan(plan_req(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000));
    add_plan(plan_start(SAT_MIN, 1'b0));                // negative saturation
    add_plan(plan_req(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000));
    add_plan(plan_start(SAT_MAX, 1'b0));                // min times min
    add_plan(plan_req(OP_LOAD_A, 3'd0, 3'd0, 32'hFFFF_FFFF));
    add_plan(plan_req(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_0001));
    add_plan(plan_start(32'hFFFF_FFFF, 1'b0));          // floor of a tiny negative
    add_plan(plan_req(OP_LOAD_A, 3'd7, 3'd7, 32'h1234_5678));   // outside sizes
    add_plan(plan_req(OP_LOAD_B, 3'd1, 3'd0, 32'h0000_0000));   // outside sizes
    add_plan(plan_req(OP_UNUSED, 3'd7, 3'd7, 32'hFFFF_FFFF));   // unused op
    add_plan(plan_start(32'hFFFF_FFFF, 1'b0));          // stores untouched
    add_plan(plan_size(REG_A_COLS, 4'd2));
    add_plan(plan_start('0, 1'b1));                     // inner sizes differ
    add_plan(plan_size(REG_A_COLS, 4'd0));              // zero acts as one
    add_plan(plan_start(32'hFFFF_FFFF, 1'b0));
    add_plan(plan_req(OP_LOAD_B, 3'd0, 3'd0, 32'h0000_0000));
    add_plan(plan_start('0, 1'b0));

    // reset
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    gap_pct   = 20;
    stall_pct = 15;
    foreach (plan[p]) begin
      if (plan[p].is_size) begin
        wait_drained();
        set_size(plan[p].ridx, plan[p].rval);
      end else begin
        send_request(plan[p].op, plan[p].row, plan[p].col, plan[p].value,
                     plan[p].typed, plan[p].want);
      end
    end

    // random phases: sizes, then a burst of loads and starts
    phase = 0;
    while (taken_count < ITEM_TARGET) begin
      wait_drained();
      case (phase)
        0: sz = '{4'd8, 4'd1, 4'd1, 4'd8};      // widest output
        1: sz = '{4'd1, 4'd8, 4'd8, 4'd1};      // longest dot product
        2: sz = '{4'd15, 4'd0, 4'd9, 4'd0};     // clamps, mismatched
        default: begin
          foreach (sz[r]) sz[r] = pick_size();
          if ($urandom_range(0, 99) < 75) sz[REG_B_ROWS] = sz[REG_A_COLS];
        end
      endcase
      set_size(REG_A_ROWS, sz[0]);
      set_size(REG_A_COLS, sz[1]);
      set_size(REG_B_ROWS, sz[2]);
      set_size(REG_B_COLS, sz[3]);
      ar = eff_size(size_reg[REG_A_ROWS]);
      ac = eff_size(size_reg[REG_A_COLS]);
      br = eff_size(size_reg[REG_B_ROWS]);
      bc = eff_size(size_reg[REG_B_COLS]);

      if (taken_count >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      case ($urandom_range(0, 2))
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 15; stall_pct = 10; end
        default: begin gap_pct = 40; stall_pct = 35; end
      endcase

      n_req = $urandom_range(6, 24);
      repeat (n_req) begin
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
          fill_unwritten();
          send_request(OP_START, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(),
                       1'b0, '0);
        end else if (sel < 25) begin
          send_request(OP_UNUSED, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(),
                       1'b0, '0);
        end else if (sel < 40) begin
          // anywhere in the index range, often outside the sizes
          send_request($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, IDX_W'($urandom()),
                       IDX_W'($urandom()), pick_value(), 1'b0, '0);
        end else if ($urandom_range(0, 1)) begin
          send_request(OP_LOAD_A, IDX_W'($urandom_range(0, ar - 1)),
                       IDX_W'($urandom_range(0, ac - 1)), pick_value(), 1'b0, '0);
        end else begin
          send_request(OP_LOAD_B, IDX_W'($urandom_range(0, br - 1)),
                       IDX_W'($urandom_range(0, bc - 1)), pick_value(), 1'b0, '0);
        end
      end
      // every phase ends with a start, on complete operands when the inner sizes agree
      fill_unwritten();
      send_request(OP_START, IDX_W'($urandom()), IDX_W'($urandom()), $urandom(), 1'b0, '0);
      phase++;
    end

    wait_drained();
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
